@@ design/shade_bob_stamp_engine_assert.svh @@
// Assertion macros used by the shade bob stamp engine RTL (sbse_back).
// SBSE_ASSERT_NOW checks the consequent in the same cycle as the antecedent.
// SBSE_ASSERT_NEXT checks the consequent in the cycle after the antecedent.
`ifndef SHADE_BOB_STAMP_ENGINE_ASSERT_SVH
`define SHADE_BOB_STAMP_ENGINE_ASSERT_SVH

`define SBSE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`define SBSE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sbse_pkg.sv @@
// ----------------------------------------------------------------------------
// sbse_pkg
// Types and constants shared by the shade bob stamp engine modules.
// ----------------------------------------------------------------------------
package sbse_pkg;

    localparam int SCREEN_WIDTH_DEF  = 320;
    localparam int SCREEN_HEIGHT_DEF = 200;
    localparam int TRAIL_MAX_DEF     = 1024;

    localparam int QUEUE_DEPTH = 2;

    localparam int KIND_W      = 2;
    localparam int ADDR_W      = 16;
    localparam int PIX_W       = 8;
    localparam int CENTER_W    = 16;
    localparam int RADIUS_W    = 3;
    localparam int LENGTH_W    = 11;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 11;
    // center plus or minus radius, with sign
    localparam int COORD_W     = 18;

    localparam logic [PIX_W-1:0]    PIX_MAX          = 8'd255;
    localparam logic [PIX_W-1:0]    BRIGHT_STEP_RST  = 8'd4;
    localparam logic [PIX_W-1:0]    BRIGHT_LIMIT_RST = 8'd250;
    localparam logic [PIX_W-1:0]    DARK_STEP_RST    = 8'd10;
    localparam logic [PIX_W-1:0]    DARK_LOW_RST     = 8'd10;
    localparam logic [PIX_W-1:0]    DARK_HIGH_RST    = 8'd254;
    localparam logic [RADIUS_W-1:0] OUTER_RADIUS_RST = 3'd5;
    localparam logic [RADIUS_W-1:0] INNER_RADIUS_RST = 3'd2;
    localparam logic [LENGTH_W-1:0] TRAIL_LENGTH_RST = 11'd1000;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_STAMP = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_BRIGHT_STEP  = 3'd0,
        REG_BRIGHT_LIMIT = 3'd1,
        REG_DARK_STEP    = 3'd2,
        REG_DARK_LOW     = 3'd3,
        REG_DARK_HIGH    = 3'd4,
        REG_OUTER_RADIUS = 3'd5,
        REG_INNER_RADIUS = 3'd6,
        REG_TRAIL_LENGTH = 3'd7
    } reg_index_t;

    typedef struct packed {
        logic [PIX_W-1:0]    bright_step;
        logic [PIX_W-1:0]    bright_limit;
        logic [PIX_W-1:0]    dark_step;
        logic [PIX_W-1:0]    dark_low;
        logic [PIX_W-1:0]    dark_high;
        logic [RADIUS_W-1:0] outer_radius;
        logic [RADIUS_W-1:0] inner_radius;
        logic [LENGTH_W-1:0] trail_length;
    } cfg_t;

    typedef struct packed {
        kind_t               kind;
        logic                addr_ok;
        logic [ADDR_W-1:0]   addr;
        logic [PIX_W-1:0]    value;
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
    } item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ_WAIT,
        ST_BRIGHT,
        ST_TRAIL,
        ST_TRAIL_WAIT,
        ST_DARK,
        ST_DONE
    } back_state_t;

endpackage

@@ design/sbse_cfg.sv @@
// ----------------------------------------------------------------------------
// sbse_cfg
// Configuration register file, written by index, cleared to defaults on reset.
// ----------------------------------------------------------------------------
module sbse_cfg
    import sbse_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    output cfg_t                   cfg
);

    cfg_t cfg_reg, cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (reg_index_t'(cfg_index))
                REG_BRIGHT_STEP:  cfg_next.bright_step  = cfg_wdata[PIX_W-1:0];
                REG_BRIGHT_LIMIT: cfg_next.bright_limit = cfg_wdata[PIX_W-1:0];
                REG_DARK_STEP:    cfg_next.dark_step    = cfg_wdata[PIX_W-1:0];
                REG_DARK_LOW:     cfg_next.dark_low     = cfg_wdata[PIX_W-1:0];
                REG_DARK_HIGH:    cfg_next.dark_high    = cfg_wdata[PIX_W-1:0];
                REG_OUTER_RADIUS: cfg_next.outer_radius = cfg_wdata[RADIUS_W-1:0];
                REG_INNER_RADIUS: cfg_next.inner_radius = cfg_wdata[RADIUS_W-1:0];
                REG_TRAIL_LENGTH: cfg_next.trail_length = cfg_wdata[LENGTH_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.bright_step  <= BRIGHT_STEP_RST;
            cfg_reg.bright_limit <= BRIGHT_LIMIT_RST;
            cfg_reg.dark_step    <= DARK_STEP_RST;
            cfg_reg.dark_low     <= DARK_LOW_RST;
            cfg_reg.dark_high    <= DARK_HIGH_RST;
            cfg_reg.outer_radius <= OUTER_RADIUS_RST;
            cfg_reg.inner_radius <= INNER_RADIUS_RST;
            cfg_reg.trail_length <= TRAIL_LENGTH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ design/sbse_front.sv @@
// ----------------------------------------------------------------------------
// sbse_front
// Accepts items, flags frame addresses in range and queues them for the back.
// ----------------------------------------------------------------------------
module sbse_front
    import sbse_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
)
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [KIND_W-1:0]          s_kind,
    input  logic [ADDR_W-1:0]          s_pixel_address,
    input  logic [PIX_W-1:0]           s_pixel_value,
    input  logic signed [CENTER_W-1:0] s_center_x,
    input  logic signed [CENTER_W-1:0] s_center_y,
    input  logic                       q_pop,
    output logic                       q_valid,
    output item_t                      q_item
);

    localparam int FRAME_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int QUEUE_AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1);

    item_t                slot_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    item_t                in_item;
    logic                 push;
    logic                 pop;

    always_comb begin
        in_item.kind     = kind_t'(s_kind);
        in_item.addr_ok  = (int'(s_pixel_address) < FRAME_SIZE);
        in_item.addr     = s_pixel_address;
        in_item.value    = s_pixel_value;
        in_item.center_x = $unsigned(s_center_x);
        in_item.center_y = $unsigned(s_center_y);
    end

    assign s_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_item  = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ design/sbse_back.sv @@
`include "shade_bob_stamp_engine_assert.svh"
// ----------------------------------------------------------------------------
// sbse_back
// Executes queued items: frame store load/read, bob stamp scans with a
// one-deep read-modify-write pipeline, trail ring update, result register.
// ----------------------------------------------------------------------------
module sbse_back
    import sbse_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int TRAIL_MAX     = TRAIL_MAX_DEF
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              q_valid,
    input  item_t             q_item,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [PIX_W-1:0]  m_read_value,
    output logic [KIND_W-1:0] m_done_kind
);

    localparam int FRAME_SIZE = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int FRAME_AW   = $clog2(FRAME_SIZE);
    localparam int PTR_W      = (TRAIL_MAX > 1) ? $clog2(TRAIL_MAX) : 1;
    localparam int FILL_W     = $clog2(TRAIL_MAX + 1);
    localparam int CMP_W      = (FILL_W > LENGTH_W) ? FILL_W : LENGTH_W;
    localparam int TRAIL_W    = 2 * CENTER_W;

    localparam logic [CMP_W-1:0]    LEN_MIN   = CMP_W'(2);
    localparam logic [CMP_W-1:0]    LEN_MAX   = CMP_W'(TRAIL_MAX);
    localparam logic [FRAME_AW-1:0] ROW_PITCH = FRAME_AW'(SCREEN_WIDTH);
    localparam logic [COORD_W-1:0]  COL_LIMIT = COORD_W'(SCREEN_WIDTH);
    localparam logic [COORD_W-1:0]  ROW_LIMIT = COORD_W'(SCREEN_HEIGHT);

    back_state_t          state_reg, state_next;
    item_t                item_reg, item_next;

    // scan window, coordinates kept as two's complement bit patterns
    logic [COORD_W-1:0]   col_reg, col_next;
    logic [COORD_W-1:0]   row_reg, row_next;
    logic [COORD_W-1:0]   row_start_reg, row_start_next;
    logic [COORD_W-1:0]   col_end_reg, col_end_next;
    logic [COORD_W-1:0]   row_end_reg, row_end_next;

    logic                 wr_valid_reg, wr_valid_next;
    logic                 wr_dark_reg, wr_dark_next;
    logic [FRAME_AW-1:0]  wr_addr_reg, wr_addr_next;

    logic [PTR_W-1:0]     trail_ptr_reg, trail_ptr_next;
    logic [FILL_W-1:0]    trail_fill_reg, trail_fill_next;
    logic                 trail_ok_reg, trail_ok_next;

    logic [PIX_W-1:0]     res_value_reg, res_value_next;
    logic                 out_valid_reg, out_valid_next;
    logic [PIX_W-1:0]     out_value_reg, out_value_next;
    logic [KIND_W-1:0]    out_kind_reg, out_kind_next;

    logic [PIX_W-1:0]     frame_mem [FRAME_SIZE];
    logic [PIX_W-1:0]     frame_rdata_reg;
    logic                 frame_re, frame_we;
    logic [FRAME_AW-1:0]  frame_raddr, frame_waddr;
    logic [PIX_W-1:0]     frame_wdata;

    logic [TRAIL_W-1:0]   trail_mem [TRAIL_MAX];
    logic [TRAIL_W-1:0]   trail_rdata_reg;
    logic                 trail_re, trail_we;
    logic [PTR_W-1:0]     trail_raddr, trail_waddr;
    logic [TRAIL_W-1:0]   trail_wdata;

    logic                 on_screen;
    logic                 scan_last;
    logic [FRAME_AW-1:0]  scan_addr;
    logic                 rmw_hit;
    logic [PIX_W-1:0]     rmw_value;
    logic [PIX_W:0]       bright_sum;
    logic [CMP_W-1:0]     len_raw, len_eff, ptr_inc;
    logic [PTR_W-1:0]     next_pos;
    logic [FILL_W-1:0]    fill_upd;
    logic [CENTER_W-1:0]  win_cx, win_cy;
    logic [RADIUS_W-1:0]  win_r;
    logic [COORD_W-1:0]   win_cx_ext, win_cy_ext, win_r_ext;

    // ---------------- scan address and bounds ----------------
    assign on_screen = !col_reg[COORD_W-1] && !row_reg[COORD_W-1]
                    && (col_reg < COL_LIMIT) && (row_reg < ROW_LIMIT);
    assign scan_addr = FRAME_AW'(row_reg) * ROW_PITCH + FRAME_AW'(col_reg);
    assign scan_last = (col_reg == col_end_reg) && (row_reg == row_end_reg);

    // ---------------- write stage of the pixel pipeline ----------------
    assign bright_sum = {1'b0, frame_rdata_reg} + {1'b0, cfg.bright_step};

    always_comb begin
        if (wr_dark_reg) begin
            rmw_hit   = (frame_rdata_reg > cfg.dark_low) && (frame_rdata_reg < cfg.dark_high);
            rmw_value = (frame_rdata_reg > cfg.dark_step) ? frame_rdata_reg - cfg.dark_step
                                                         : '0;
        end else begin
            rmw_hit   = (frame_rdata_reg < cfg.bright_limit);
            rmw_value = bright_sum[PIX_W] ? PIX_MAX : bright_sum[PIX_W-1:0];
        end
    end

    // ---------------- trail ring position ----------------
    assign len_raw  = CMP_W'(cfg.trail_length);
    assign len_eff  = (len_raw < LEN_MIN) ? LEN_MIN : ((len_raw > LEN_MAX) ? LEN_MAX : len_raw);
    assign ptr_inc  = CMP_W'(trail_ptr_reg) + 1'b1;
    assign next_pos = (ptr_inc >= len_eff) ? '0 : ptr_inc[PTR_W-1:0];
    // ring entries are written in order from zero, so a fill mark tells written ones
    assign fill_upd = (FILL_W'(ptr_inc) > trail_fill_reg) ? FILL_W'(ptr_inc) : trail_fill_reg;

    // ---------------- window source ----------------
    always_comb begin
        if (state_reg == ST_TRAIL_WAIT) begin
            win_cx = trail_rdata_reg[TRAIL_W-1:CENTER_W];
            win_cy = trail_rdata_reg[CENTER_W-1:0];
            win_r  = cfg.inner_radius;
        end else begin
            win_cx = item_reg.center_x;
            win_cy = item_reg.center_y;
            win_r  = cfg.outer_radius;
        end
    end

    assign win_cx_ext = {{(COORD_W-CENTER_W){win_cx[CENTER_W-1]}}, win_cx};
    assign win_cy_ext = {{(COORD_W-CENTER_W){win_cy[CENTER_W-1]}}, win_cy};
    assign win_r_ext  = {{(COORD_W-RADIUS_W){1'b0}}, win_r};

    // ---------------- sequencer ----------------
    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        row_start_next  = row_start_reg;
        col_end_next    = col_end_reg;
        row_end_next    = row_end_reg;
        wr_valid_next   = 1'b0;
        wr_dark_next    = wr_dark_reg;
        wr_addr_next    = scan_addr;
        trail_ptr_next  = trail_ptr_reg;
        trail_fill_next = trail_fill_reg;
        trail_ok_next   = trail_ok_reg;
        res_value_next  = res_value_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        out_value_next  = out_value_reg;
        out_kind_next   = out_kind_reg;
        q_pop           = 1'b0;

        frame_re    = 1'b0;
        frame_raddr = scan_addr;
        frame_we    = wr_valid_reg && rmw_hit;
        frame_waddr = wr_addr_reg;
        frame_wdata = rmw_value;

        trail_re    = 1'b0;
        trail_raddr = next_pos;
        trail_we    = 1'b0;
        trail_waddr = trail_ptr_reg;
        trail_wdata = {item_reg.center_x, item_reg.center_y};

        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                res_value_next = '0;
                case (item_reg.kind)
                    KIND_LOAD: begin
                        frame_we    = item_reg.addr_ok;
                        frame_waddr = FRAME_AW'(item_reg.addr);
                        frame_wdata = item_reg.value;
                        state_next  = ST_DONE;
                    end
                    KIND_READ: begin
                        frame_re    = item_reg.addr_ok;
                        frame_raddr = FRAME_AW'(item_reg.addr);
                        state_next  = ST_READ_WAIT;
                    end
                    KIND_STAMP: begin
                        col_next       = win_cx_ext - win_r_ext;
                        row_next       = win_cy_ext - win_r_ext;
                        row_start_next = win_cy_ext - win_r_ext;
                        col_end_next   = win_cx_ext + win_r_ext;
                        row_end_next   = win_cy_ext + win_r_ext;
                        wr_dark_next   = 1'b0;
                        state_next     = ST_BRIGHT;
                    end
                    default: begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_READ_WAIT: begin
                res_value_next = item_reg.addr_ok ? frame_rdata_reg : '0;
                state_next     = ST_DONE;
            end
            ST_BRIGHT, ST_DARK: begin
                frame_re      = on_screen;
                wr_valid_next = on_screen;
                wr_dark_next  = (state_reg == ST_DARK);
                if (row_reg == row_end_reg) begin
                    row_next = row_start_reg;
                    col_next = col_reg + 1'b1;
                end else begin
                    row_next = row_reg + 1'b1;
                end
                if (scan_last) begin
                    state_next = (state_reg == ST_DARK) ? ST_DONE : ST_TRAIL;
                end
            end
            ST_TRAIL: begin
                trail_we        = 1'b1;
                trail_re        = 1'b1;
                trail_fill_next = fill_upd;
                trail_ok_next   = (FILL_W'(next_pos) < fill_upd);
                trail_ptr_next  = next_pos;
                state_next      = ST_TRAIL_WAIT;
            end
            ST_TRAIL_WAIT: begin
                if (trail_ok_reg && (trail_rdata_reg != '0)) begin
                    col_next       = win_cx_ext - win_r_ext;
                    row_next       = win_cy_ext - win_r_ext;
                    row_start_next = win_cy_ext - win_r_ext;
                    col_end_next   = win_cx_ext + win_r_ext;
                    row_end_next   = win_cy_ext + win_r_ext;
                    state_next     = ST_DARK;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold until the result register is free
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_value_next = res_value_reg;
                    out_kind_next  = item_reg.kind;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            wr_valid_reg   <= 1'b0;
            wr_dark_reg    <= 1'b0;
            trail_ptr_reg  <= '0;
            trail_fill_reg <= '0;
            trail_ok_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            wr_valid_reg   <= wr_valid_next;
            wr_dark_reg    <= wr_dark_next;
            trail_ptr_reg  <= trail_ptr_next;
            trail_fill_reg <= trail_fill_next;
            trail_ok_reg   <= trail_ok_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg      <= item_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        row_start_reg <= row_start_next;
        col_end_reg   <= col_end_next;
        row_end_reg   <= row_end_next;
        wr_addr_reg   <= wr_addr_next;
        res_value_reg <= res_value_next;
        out_value_reg <= out_value_next;
        out_kind_reg  <= out_kind_next;
    end

    // ---------------- memories ----------------
    always_ff @(posedge aclk) begin
        if (frame_we) begin
            frame_mem[frame_waddr] <= frame_wdata;
        end
        if (frame_re) begin
            frame_rdata_reg <= frame_mem[frame_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (trail_we) begin
            trail_mem[trail_waddr] <= trail_wdata;
        end
        if (trail_re) begin
            trail_rdata_reg <= trail_mem[trail_raddr];
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_read_value = out_value_reg;
    assign m_done_kind  = out_kind_reg;

    // ---------------- assertions ----------------
    `SBSE_ASSERT_NOW(a_fill_covers_ptr, aclk, aresetn, 1'b1, FILL_W'(trail_ptr_reg) <= trail_fill_reg, "trail pointer beyond fill mark")
    `SBSE_ASSERT_NOW(a_frame_no_rw_clash, aclk, aresetn, frame_we && frame_re, frame_waddr != frame_raddr, "frame read and write at the same address")
    `SBSE_ASSERT_NEXT(a_wr_stage_from_scan, aclk, aresetn, !(state_reg == ST_BRIGHT || state_reg == ST_DARK), !wr_valid_reg, "pixel write stage without a scan")
    `SBSE_ASSERT_NOW(a_result_from_done, aclk, aresetn, $rose(out_valid_reg), $past(state_reg) == ST_DONE, "result loaded outside the done state")

endmodule

@@ design/shade_bob_stamp_engine.sv @@
// ----------------------------------------------------------------------------
// shade_bob_stamp_engine
// Frame store with bob stamping: brighten a square around each center, keep
// a trail ring of centers, darken an inner-radius square around the oldest one.
//
//   channel   direction  handshake           payload
//   s_*       in         s_valid / s_ready   kind, pixel_address, pixel_value,
//                                            center_x, center_y
//   m_*       out        m_valid / m_ready   read_value, done_kind
//   cfg_*     in         cfg_we              cfg_index, cfg_wdata
//
// Load and unknown kinds pass the execute and done states; read adds read wait.
// Stamp scans (2*outer_radius+1)^2 pixels, writes the trail ring, and if the
// oldest entry is written and not (0,0), (2*inner_radius+1)^2 more. The scans
// visit one pixel per cycle through the frame memory's read and write ports.
// Two items queue ahead of the sequencer; a full result register stalls it.
// No clearing pass after reset: the trail ring is tracked by a fill mark.
// ----------------------------------------------------------------------------
module shade_bob_stamp_engine
    import sbse_pkg::*;
#(
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
    parameter int TRAIL_MAX     = TRAIL_MAX_DEF
)
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [KIND_W-1:0]          s_kind,
    input  logic [ADDR_W-1:0]          s_pixel_address,
    input  logic [PIX_W-1:0]           s_pixel_value,
    input  logic signed [CENTER_W-1:0] s_center_x,
    input  logic signed [CENTER_W-1:0] s_center_y,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [PIX_W-1:0]           m_read_value,
    output logic [KIND_W-1:0]          m_done_kind
);

    cfg_t  cfg;
    logic  q_valid;
    logic  q_pop;
    item_t q_item;

    sbse_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sbse_front #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_pixel_address (s_pixel_address),
        .s_pixel_value   (s_pixel_value),
        .s_center_x      (s_center_x),
        .s_center_y      (s_center_y),
        .q_pop           (q_pop),
        .q_valid         (q_valid),
        .q_item          (q_item)
    );

    sbse_back #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .TRAIL_MAX     (TRAIL_MAX)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_done_kind  (m_done_kind)
    );

endmodule
